/* rtl/core/rzs_pkg.sv */
// rolling z-score signal: shared constants, codes and word types
`default_nettype none

package rzs_pkg;

  localparam int unsigned WINDOW_DEF  = 8;
  localparam int unsigned PRICE_W     = 24;
  localparam int unsigned SPREAD_W    = PRICE_W + 1;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned NUM_SIG     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SIG_LONG  = 2'd0,
    SIG_SHORT = 2'd1,
    SIG_CLOSE = 2'd2,
    SIG_NONE  = 2'd3
  } rzs_sig_e;

  // one classified word on its way from the front to the back
  typedef struct packed {
    logic signed [SPREAD_W-1:0] spread;
    logic                       restart;
    logic                       decide;
  } rzs_entry_t;

  typedef struct packed {
    logic       valid;
    rzs_entry_t entry;
  } rzs_push_t;

  typedef struct packed {
    logic       valid;
    rzs_entry_t entry;
  } rzs_head_t;

endpackage

`default_nettype wire

/* rtl/core/rzs_front.sv */
// front end: accepts price words, forms the spread and tags fill or decide
`default_nettype none

module rzs_front import rzs_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PRICE_W-1:0] price_a_i,
  input  wire logic [PRICE_W-1:0] price_b_i,
  input  wire logic               restart_i,
  input  wire logic               full_i,
  output rzs_push_t               push_o
);

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic              accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // saturating count of words seen since reset or restart
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (restart_i) begin
        fill_d = FILL_W'(1);
      end else if (fill_q != FILL_MAX) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign push_o.valid          = accept;
  assign push_o.entry.spread   = $signed({1'b0, price_a_i} - {1'b0, price_b_i});
  assign push_o.entry.restart  = restart_i;
  assign push_o.entry.decide   = !restart_i && (fill_q == FILL_MAX);

endmodule

`default_nettype wire

/* rtl/core/rzs_queue.sv */
// short fifo between the front end and the back end
`default_nettype none

module rzs_queue import rzs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rzs_push_t push_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output rzs_head_t      head_o
);

  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  rzs_entry_t        entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_LAST) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_LAST) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = entries_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/core/rzs_back.sv */
// back end: spread ring, running sums, shared squarer and signal decision
`default_nettype none

module rzs_back import rzs_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rzs_head_t           head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               signal_o,
  output logic [COUNT_W-1:0]       count_long_o,
  output logic [COUNT_W-1:0]       count_short_o,
  output logic [COUNT_W-1:0]       count_close_o,
  output logic [COUNT_W-1:0]       count_none_o
);

  localparam int unsigned LW     = $clog2(WINDOW);
  localparam int unsigned PTR_W  = LW;
  localparam int unsigned SUM_W  = SPREAD_W + LW;
  localparam int unsigned D_W    = SUM_W + 1;
  localparam int unsigned MAG_W  = SUM_W;
  localparam int unsigned XX_W   = 2 * PRICE_W;
  localparam int unsigned SQ_W   = XX_W + LW;
  localparam int unsigned V_W    = SQ_W + LW;
  localparam int unsigned P_W    = 2 * MAG_W;
  localparam int unsigned CMP_W  = P_W + 5;

  localparam logic [PTR_W-1:0]       PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic signed [D_W-1:0]  WIN_D    = D_W'(WINDOW);
  localparam logic [V_W-1:0]         WIN_V    = V_W'(WINDOW);
  localparam logic [COUNT_W-1:0]     CNT_MAX  = '1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_READ   = 8'b0000_0010,
    ST_SQX    = 8'b0000_0100,
    ST_SQO    = 8'b0000_1000,
    ST_SQD    = 8'b0001_0000,
    ST_SQS    = 8'b0010_0000,
    ST_VAR    = 8'b0100_0000,
    ST_COMMIT = 8'b1000_0000
  } rzs_state_e;

  rzs_state_e state_q, state_d;

  // spread ring memory
  logic signed [SPREAD_W-1:0] ring_q [WINDOW];
  logic signed [SPREAD_W-1:0] rd_q;
  logic [PTR_W-1:0]           rd_addr;
  logic                       ring_re;

  // word under work
  logic signed [SPREAD_W-1:0] x_q, old_q;
  logic                       decide_q;
  logic signed [D_W-1:0]      d_q;
  logic [XX_W-1:0]            xx_q, oo_q;
  logic [P_W-1:0]             d2_q;
  logic [V_W-1:0]             s2_q, v_q;

  // window state
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [SQ_W-1:0]            sq_q, sq_d;
  logic [PTR_W-1:0]           ptr_q;
  logic [COUNT_W-1:0]         cnt_q [NUM_SIG];
  logic [COUNT_W-1:0]         cnt_d [NUM_SIG];

  // result register
  logic                       out_valid_q;
  rzs_sig_e                   out_sig_q;
  logic [COUNT_W-1:0]         out_cnt_q [NUM_SIG];

  logic                       pop, commit_go;
  logic signed [D_W-1:0]      x_d_ext, sum_d_ext, d_next, d_abs_s;
  logic signed [SUM_W-1:0]    x_s_ext, old_s_ext, sum_abs_s;
  logic [MAG_W-1:0]           mul_op;
  logic [P_W-1:0]             prod;
  logic [CMP_W-1:0]           d2_w, d2x25, v16;
  logic                       d2_gt_v, d_pos, d_neg;
  rzs_sig_e                   sig;

  function automatic logic [PRICE_W-1:0] spread_mag(logic signed [SPREAD_W-1:0] v);
    logic [SPREAD_W-1:0] n;
    n = v[SPREAD_W-1] ? -v : v;
    return n[PRICE_W-1:0];
  endfunction

  assign pop       = (state_q == ST_IDLE) && head_i.valid;
  assign pop_o     = pop;
  assign commit_go = (state_q == ST_COMMIT) && (!decide_q || !out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (head_i.valid) state_d = ST_READ;
      ST_READ:   state_d = ST_SQX;
      ST_SQX:    state_d = ST_SQO;
      ST_SQO:    state_d = decide_q ? ST_SQD : ST_COMMIT;
      ST_SQD:    state_d = ST_SQS;
      ST_SQS:    state_d = ST_VAR;
      ST_VAR:    state_d = ST_COMMIT;
      ST_COMMIT: if (commit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sign extensions and magnitudes
  assign x_d_ext   = $signed({{(D_W - SPREAD_W){x_q[SPREAD_W-1]}}, x_q});
  assign sum_d_ext = $signed({sum_q[SUM_W-1], sum_q});
  assign d_next    = (x_d_ext * WIN_D) - sum_d_ext;
  assign d_abs_s   = d_q[D_W-1] ? -d_q : d_q;
  assign sum_abs_s = sum_q[SUM_W-1] ? -sum_q : sum_q;
  assign x_s_ext   = $signed({{(SUM_W - SPREAD_W){x_q[SPREAD_W-1]}}, x_q});
  assign old_s_ext = $signed({{(SUM_W - SPREAD_W){old_q[SPREAD_W-1]}}, old_q});

  // shared squarer
  always_comb begin
    case (state_q)
      ST_SQX:  mul_op = MAG_W'(spread_mag(x_q));
      ST_SQO:  mul_op = MAG_W'(spread_mag(old_q));
      ST_SQD:  mul_op = d_abs_s[MAG_W-1:0];
      ST_SQS:  mul_op = sum_abs_s[MAG_W-1:0];
      default: mul_op = '0;
    endcase
  end

  assign prod = P_W'(mul_op) * P_W'(mul_op);

  // decision: d*d against V, and 25*d*d against 16*V
  assign d2_w    = CMP_W'(d2_q);
  assign d2x25   = (d2_w << 4) + (d2_w << 3) + d2_w;
  assign v16     = CMP_W'(v_q) << 4;
  assign d2_gt_v = d2_w > CMP_W'(v_q);
  assign d_neg   = d_q[D_W-1];
  assign d_pos   = !d_neg && (d_q != '0);

  always_comb begin
    if (d_pos && d2_gt_v) begin
      sig = SIG_LONG;
    end else if (d_neg && d2_gt_v) begin
      sig = SIG_SHORT;
    end else if (v16 > d2x25) begin
      sig = SIG_CLOSE;
    end else begin
      sig = SIG_NONE;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SIG; i++) begin
      cnt_d[i] = cnt_q[i];
      if ((2'(i) == sig) && (cnt_q[i] != CNT_MAX)) begin
        cnt_d[i] = cnt_q[i] + COUNT_W'(1);
      end
    end
  end

  assign sum_d = sum_q + x_s_ext - old_s_ext;
  assign sq_d  = sq_q + SQ_W'(xx_q) - SQ_W'(oo_q);

  // ring memory, read one word ahead of the update
  assign ring_re = pop;
  assign rd_addr = head_i.entry.restart ? '0 : ptr_q;

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      ring_q[ptr_q] <= x_q;
    end
    if (ring_re) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sq_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SIG; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop && head_i.entry.restart) begin
        sum_q <= '0;
        sq_q  <= '0;
        ptr_q <= '0;
        for (int i = 0; i < NUM_SIG; i++) begin
          cnt_q[i] <= '0;
        end
      end else if (commit_go) begin
        sum_q <= sum_d;
        sq_q  <= sq_d;
        ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
        if (decide_q) begin
          for (int i = 0; i < NUM_SIG; i++) begin
            cnt_q[i] <= cnt_d[i];
          end
        end
      end
      if (commit_go && decide_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      x_q      <= head_i.entry.spread;
      decide_q <= head_i.entry.decide;
    end
    if (state_q == ST_READ) begin
      old_q <= decide_q ? rd_q : '0;
      d_q   <= d_next;
    end
    if (state_q == ST_SQX) begin
      xx_q <= prod[XX_W-1:0];
    end
    if (state_q == ST_SQO) begin
      oo_q <= prod[XX_W-1:0];
    end
    if (state_q == ST_SQD) begin
      d2_q <= prod;
    end
    if (state_q == ST_SQS) begin
      s2_q <= prod[V_W-1:0];
    end
    if (state_q == ST_VAR) begin
      v_q <= (V_W'(sq_q) * WIN_V) - s2_q;
    end
    if (commit_go && decide_q) begin
      out_sig_q <= sig;
      for (int i = 0; i < NUM_SIG; i++) begin
        out_cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign signal_o      = out_sig_q;
  assign count_long_o  = out_cnt_q[SIG_LONG];
  assign count_short_o = out_cnt_q[SIG_SHORT];
  assign count_close_o = out_cnt_q[SIG_CLOSE];
  assign count_none_o  = out_cnt_q[SIG_NONE];

endmodule

`default_nettype wire

/* rtl/core/rolling_zscore_signal_top.sv */
// rolling z-score pair signal: top level joining front end, queue and back end
// a decided word goes from the queue through the back end read, square, variance and
// commit states, where out_valid_o rises; the back end takes no new word until it has
//   committed the last, its sequencer driving its one shared squarer
// a 2-word queue lets the input keep taking words while the back end works
// reset: async active low, clears sums, counts, pointers, queue and both handshakes;
//   the spread ring holds no reset value and needs no clearing pass
`default_nettype none

module rolling_zscore_signal_top import rzs_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input word channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PRICE_W-1:0] price_a_i,
  input  wire logic [PRICE_W-1:0] price_b_i,
  input  wire logic               restart_i,
  // result word channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              signal_o,
  output logic [COUNT_W-1:0]      count_long_o,
  output logic [COUNT_W-1:0]      count_short_o,
  output logic [COUNT_W-1:0]      count_close_o,
  output logic [COUNT_W-1:0]      count_none_o
);

  rzs_push_t push;
  rzs_head_t head;
  logic      q_full;
  logic      q_pop;

  // front end: spread = price_a - price_b, tagged as fill or decide by
  // its own count of words since reset or restart
  rzs_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .price_a_i  (price_a_i),
    .price_b_i  (price_b_i),
    .restart_i  (restart_i),
    .full_i     (q_full),
    .push_o     (push)
  );

  // decoupling queue
  rzs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (head)
  );

  // back end: ring read, squares of x, old entry, d and sum, variance,
  // then the decision and the window update in one commit step;
  // fill words skip the decision steps and give no result
  rzs_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .signal_o      (signal_o),
    .count_long_o  (count_long_o),
    .count_short_o (count_short_o),
    .count_close_o (count_close_o),
    .count_none_o  (count_none_o)
  );

endmodule

`default_nettype wire

/* rtl/core/rzs_checker.sv */
// port-level checks for the rolling z-score signal block, with bind
`default_nettype none

module rzs_checker import rzs_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [1:0]         signal_o,
  input wire logic [COUNT_W-1:0] count_long_o,
  input wire logic [COUNT_W-1:0] count_short_o,
  input wire logic [COUNT_W-1:0] count_close_o,
  input wire logic [COUNT_W-1:0] count_none_o
);

  // a stalled result word stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(signal_o) && $stable(count_long_o) &&
      $stable(count_short_o) && $stable(count_close_o) && $stable(count_none_o))
    else $error("result word changed while stalled");

  // the count of the reported signal already includes this word
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (signal_o == SIG_LONG  && count_long_o  != '0) ||
      (signal_o == SIG_SHORT && count_short_o != '0) ||
      (signal_o == SIG_CLOSE && count_close_o != '0) ||
      (signal_o == SIG_NONE  && count_none_o  != '0))
    else $error("reported signal has a zero count");

endmodule

bind rolling_zscore_signal_top rzs_checker u_rzs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .signal_o      (signal_o),
  .count_long_o  (count_long_o),
  .count_short_o (count_short_o),
  .count_close_o (count_close_o),
  .count_none_o  (count_none_o)
);

`default_nettype wire
